/* hw/rtl/button_auto_repeat_core_macros.svh */
// assertion macros used by the checker file
`ifndef BUTTON_AUTO_REPEAT_CORE_MACROS_SVH
`define BUTTON_AUTO_REPEAT_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BAR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BAR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/bar_pkg.sv */
package bar_pkg;

    localparam int FIELD_W            = 16;
    localparam int BUTTONS_DEFAULT    = 16;
    localparam int COUNT_BITS_DEFAULT = 10;
    localparam int CFG_INDEX_W        = 2;
    localparam int DELAY_W            = 8;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 8'd30;
    localparam logic [DELAY_W-1:0] FAST_RESET  = 8'h20;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_REPEAT_DELAY = 2'd0,
        CFG_FAST_AFTER   = 2'd1,
        CFG_REPEAT_MASK  = 2'd2,
        CFG_ONCE_MASK    = 2'd3
    } cfg_index_t;

endpackage

/* hw/rtl/button_auto_repeat_core.sv */
// Button auto-repeat: one held-button mask in, one press-event mask out per
// transfer. The block sustains one item per clock while out_ready is high: an item
// passes through the input register, where every button's hold counter is
// compared and stepped in parallel, and then sits in the output register until
// taken. in_ready drops only while both registers are full and the output is
// stalled. Configuration writes are taken every cycle and must be issued only
// while no item is in flight.
module button_auto_repeat_core #(
    parameter int BUTTONS    = bar_pkg::BUTTONS_DEFAULT,
    parameter int COUNT_BITS = bar_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bar_pkg::FIELD_W-1:0]       held_buttons,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bar_pkg::FIELD_W-1:0]       button_events,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bar_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bar_pkg::FIELD_W-1:0]       cfg_data
);
    import bar_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_TOP     = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_TOP_M1  = {{(COUNT_BITS-1){1'b1}}, 1'b0};

    logic [DELAY_W-1:0]    repeat_delay_reg;
    logic [DELAY_W-1:0]    fast_after_reg;
    logic [BUTTONS-1:0]    repeat_mask_reg;
    logic [BUTTONS-1:0]    once_mask_reg;

    logic                  stage_valid_reg;
    logic [BUTTONS-1:0]    held_reg;
    logic                  out_valid_reg;
    logic [FIELD_W-1:0]    events_reg;
    logic [FIELD_W-1:0]    events_next;

    logic [COUNT_BITS-1:0] hold_count_reg [BUTTONS];
    logic [COUNT_BITS-1:0] hold_count_next [BUTTONS];
    logic [BUTTONS-1:0]    prev_held_reg;
    logic [BUTTONS-1:0]    repeat_fire;
    logic [BUTTONS-1:0]    once_fire;

    logic                  out_free;
    logic                  stage_fire;
    logic [COUNT_BITS-1:0] delay_ext;
    logic [COUNT_BITS-1:0] fast_ext;

    assign out_free   = !out_valid_reg || out_ready;
    assign stage_fire = stage_valid_reg && out_free;
    assign in_ready   = !stage_valid_reg || out_free;
    assign out_valid  = out_valid_reg;
    assign button_events = events_reg;
    assign cfg_ready  = 1'b1;

    assign delay_ext = COUNT_BITS'(repeat_delay_reg);
    assign fast_ext  = COUNT_BITS'(fast_after_reg);

    // per-button hold counter and repeat decision
    for (genvar b = 0; b < BUTTONS; b++)
    begin : g_btn
        logic [COUNT_BITS-1:0] cnt;
        logic [COUNT_BITS-1:0] rel;
        logic                  active;
        logic                  due;

        assign cnt    = hold_count_reg[b];
        assign active = repeat_mask_reg[b] && held_reg[b];
        assign rel    = cnt - delay_ext;
        assign due    = (cnt == '0)
                     || ((cnt >= delay_ext)
                         && (((rel > fast_ext) && !rel[0]) || (rel[1:0] == 2'b00)));
        assign repeat_fire[b] = active && due;

        always_comb
        begin
            if (!active)
            begin
                hold_count_next[b] = '0;
            end
            else if (cnt == COUNT_TOP)
            begin
                hold_count_next[b] = COUNT_TOP_M1;
            end
            else
            begin
                hold_count_next[b] = cnt + 1'b1;
            end
        end
    end

    assign once_fire   = held_reg & ~prev_held_reg & once_mask_reg;
    assign events_next = FIELD_W'(repeat_fire | once_fire);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_delay_reg <= DELAY_RESET;
            fast_after_reg   <= FAST_RESET;
            repeat_mask_reg  <= '0;
            once_mask_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_REPEAT_DELAY: repeat_delay_reg <= cfg_data[DELAY_W-1:0];
                CFG_FAST_AFTER:   fast_after_reg   <= cfg_data[DELAY_W-1:0];
                CFG_REPEAT_MASK:  repeat_mask_reg  <= cfg_data[BUTTONS-1:0];
                CFG_ONCE_MASK:    once_mask_reg    <= cfg_data[BUTTONS-1:0];
                default:          ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            held_reg <= held_buttons[BUTTONS-1:0];
        end
    end

    // button state, stepped once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_held_reg <= '0;
            for (int i = 0; i < BUTTONS; i++)
            begin
                hold_count_reg[i] <= '0;
            end
        end
        else if (stage_fire)
        begin
            prev_held_reg <= held_reg;
            for (int i = 0; i < BUTTONS; i++)
            begin
                hold_count_reg[i] <= hold_count_next[i];
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire)
        begin
            events_reg <= events_next;
        end
    end

endmodule

/* hw/rtl/bar_checker.sv */
`include "button_auto_repeat_core_macros.svh"

module bar_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [bar_pkg::FIELD_W-1:0]   button_events
);
    import bar_pkg::*;

    // stalled result holds
    `BAR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(button_events), "result changed while stalled")

    // second item behind a stalled result fills the pipe
    `BAR_ASSERT_NXT(a_full_stall, in_valid && in_ready && out_valid && !out_ready, out_ready || !in_ready, "input taken with both stages full")

    // a transfer into an empty output side shows up at the output after the input register
    `BAR_ASSERT_NXT(a_in_to_out, in_valid && in_ready && !out_valid, ##1 out_valid, "accepted item did not reach the output")

    // results leave only by transfer
    `BAR_ASSERT_IMP(a_out_drop, $fell(out_valid), $past(out_ready), "result dropped without transfer")

endmodule

bind button_auto_repeat_core bar_checker u_bar_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .button_events (button_events)
);

/* tb/sv/tb_button_auto_repeat_core.sv */
module tb_button_auto_repeat_core;

    import bar_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 6;
    localparam int NUM_BUTTONS     = BUTTONS_DEFAULT;
    localparam int HOLD_W          = COUNT_BITS_DEFAULT;
    localparam int HOLD_TOP        = (1 << HOLD_W) - 1;
    localparam int SETTLE_CYCLES   = 3;
    localparam int CALM_TAIL       = 40;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_CYCLES = 400000;

    typedef enum logic [0:0] {
        XFER_BUTTONS,
        XFER_REGISTER
    } xfer_kind_t;

    typedef struct packed {
        xfer_kind_t          kind;
        cfg_index_t          index;
        logic [FIELD_W-1:0]  data;
    } poll_entry_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_ready;
    logic [FIELD_W-1:0]  held_buttons  = '0;
    logic                out_valid;
    logic                out_ready     = 1'b0;
    logic [FIELD_W-1:0]  button_events;
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    cfg_index_t          cfg_index     = CFG_REPEAT_DELAY;
    logic [FIELD_W-1:0]  cfg_data      = '0;

    // predictor state
    logic [DELAY_W-1:0]  cur_delay       = DELAY_RESET;
    logic [DELAY_W-1:0]  cur_fast        = FAST_RESET;
    logic [FIELD_W-1:0]  cur_repeat_mask = '0;
    logic [FIELD_W-1:0]  cur_once_mask   = '0;
    logic [HOLD_W-1:0]   hold_ticks [NUM_BUTTONS];
    logic [FIELD_W-1:0]  last_held       = '0;

    poll_entry_t         poll_queue [$];
    logic [FIELD_W-1:0]  awaited_events [$];

    logic                in_xfer_done  = 1'b0;
    logic                cfg_xfer_done = 1'b0;
    int                  mismatch_count = 0;
    int                  results_seen   = 0;

    int                  send_gap     = 0;
    int                  settle_left  = SETTLE_CYCLES;
    int                  polls_sent   = 0;
    bit                  send_bursty  = 1'b1;
    int                  stall_left   = 0;
    int                  recv_cycles  = 0;
    bit                  recv_bursty  = 1'b1;

    button_auto_repeat_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .held_buttons  (held_buttons),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .button_events (button_events),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            hold_ticks[b] = '0;
        end
    end

    function automatic void store_register(input cfg_index_t idx, input logic [FIELD_W-1:0] data);
        case (idx)
            CFG_REPEAT_DELAY: cur_delay       = data[DELAY_W-1:0];
            CFG_FAST_AFTER:   cur_fast        = data[DELAY_W-1:0];
            CFG_REPEAT_MASK:  cur_repeat_mask = data;
            CFG_ONCE_MASK:    cur_once_mask   = data;
            default:          ;
        endcase
    endfunction

    // one poll tick: step every hold counter and collect the press events
    function automatic logic [FIELD_W-1:0] next_press_events(input logic [FIELD_W-1:0] held);
        logic [FIELD_W-1:0] events;
        int                 count;
        int                 over;
        events = '0;
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            if (cur_repeat_mask[b] && held[b])
            begin
                count = int'(hold_ticks[b]);
                hold_ticks[b] = (count >= HOLD_TOP) ? HOLD_W'(HOLD_TOP - 1) : HOLD_W'(count + 1);
                if (count == 0)
                begin
                    events[b] = 1'b1;
                end
                else
                begin
                    over = count - int'(cur_delay);
                    if (over >= 0)
                    begin
                        if (over > int'(cur_fast) && (over % 2) == 0)
                            events[b] = 1'b1;
                        if ((over % 4) == 0)
                            events[b] = 1'b1;
                    end
                end
            end
            else
            begin
                hold_ticks[b] = '0;
            end
        end
        events = events | (held & ~last_held & cur_once_mask);
        last_held = held;
        return events;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic queue_poll(input logic [FIELD_W-1:0] held);
        poll_entry_t e;
        e.kind  = XFER_BUTTONS;
        e.index = CFG_REPEAT_DELAY;
        e.data  = held;
        poll_queue.push_back(e);
    endtask

    task automatic queue_register(input cfg_index_t idx, input logic [FIELD_W-1:0] data);
        poll_entry_t e;
        e.kind  = XFER_REGISTER;
        e.index = idx;
        e.data  = data;
        poll_queue.push_back(e);
    endtask

    task automatic queue_settings(input logic [DELAY_W-1:0] dly, input logic [DELAY_W-1:0] fst,
                                  input logic [FIELD_W-1:0] rep, input logic [FIELD_W-1:0] once);
        queue_register(CFG_REPEAT_DELAY, {8'($urandom), dly});
        queue_register(CFG_FAST_AFTER, {8'($urandom), fst});
        queue_register(CFG_REPEAT_MASK, rep);
        queue_register(CFG_ONCE_MASK, once);
    endtask

    // held buttons mostly persist, with random presses and releases and some noise ticks
    task automatic queue_holds(input int count, input logic [FIELD_W-1:0] pinned);
        logic [FIELD_W-1:0] held;
        logic [FIELD_W-1:0] flip;
        int                 rate;
        held = 16'($urandom);
        rate = $urandom_range(4, 24);
        for (int n = 0; n < count; n++)
        begin
            flip = '0;
            for (int b = 0; b < NUM_BUTTONS; b++)
            begin
                if ($urandom_range(0, rate - 1) == 0)
                    flip[b] = 1'b1;
            end
            held = held ^ flip;
            if ($urandom_range(0, 11) == 0)
                queue_poll(16'($urandom) | pinned);
            else if ($urandom_range(0, 29) == 0)
                queue_poll($urandom_range(0, 1) ? 16'hFFFF : pinned);
            else
                queue_poll(held | pinned);
        end
    endtask

    task automatic queue_random_phases(input int phases);
        logic [DELAY_W-1:0] dly;
        logic [DELAY_W-1:0] fst;
        logic [FIELD_W-1:0] rep;
        logic [FIELD_W-1:0] once;
        for (int p = 0; p < phases; p++)
        begin
            dly  = 8'($urandom_range(0, 40));
            fst  = 8'($urandom_range(0, 40));
            rep  = 16'($urandom) | 16'($urandom);
            once = 16'($urandom);
            case ($urandom_range(0, 5))
                0: begin dly = 8'd0;   fst = 8'd0;   rep = 16'hFFFF; once = 16'hFFFF; end
                1: begin dly = 8'd255; fst = 8'd255; rep = 16'h0000; once = 16'h0000; end
                2: begin dly = 8'd0;   fst = 8'd255; end
                3: begin dly = 8'd255; fst = 8'd0;   end
                default: ;
            endcase
            queue_settings(dly, fst, rep, once);
            queue_holds(45, 16'h0000);
        end
    endtask

    // stimulus
    initial
    begin
        queue_poll(16'hFFFF);
        queue_poll(16'h0000);
        // repeat only, once only, both and neither in separate nibbles
        queue_register(CFG_REPEAT_DELAY, 16'hC302);
        queue_register(CFG_FAST_AFTER, 16'h3C03);
        queue_register(CFG_REPEAT_MASK, 16'hF0F0);
        queue_register(CFG_ONCE_MASK, 16'hFF00);
        for (int n = 0; n < 12; n++)
        begin
            queue_poll(16'hFFFF);
        end
        queue_poll(16'h0000);
        queue_poll(16'h5555);
        queue_poll(16'hAAAA);
        queue_poll(16'hFFFF);
        queue_poll(16'h0000);

        queue_random_phases(2);

        // long hold so the repeat runs past the delay and into the fast rate
        queue_settings(8'd150, 8'd40, 16'($urandom) | 16'h000F, 16'($urandom));
        queue_holds(250, 16'h000F);

        queue_random_phases(2);

        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (poll_queue.size() != 0 || in_valid || cfg_valid || awaited_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #(WATCHDOG_CYCLES * CLK_PERIOD);
        $display("simulation failed");
        $finish;
    end

    // driver
    always @(negedge clk)
    begin : feed_proc
        poll_entry_t head;
        logic        in_busy;
        logic        cfg_busy;
        logic        next_in;
        logic        next_cfg;
        if (rst_n)
        begin
            in_busy  = in_valid && !in_xfer_done;
            cfg_busy = cfg_valid && !cfg_xfer_done;
            next_in  = in_busy;
            next_cfg = cfg_busy;
            if (!in_busy && !cfg_busy)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (poll_queue.size() > 0)
                begin
                    head = poll_queue[0];
                    if (head.kind == XFER_BUTTONS)
                    begin
                        void'(poll_queue.pop_front());
                        held_buttons <= head.data;
                        next_in = 1'b1;
                        polls_sent++;
                        if (polls_sent % 32 == 0)
                            send_bursty = ($urandom_range(0, 2) != 0);
                        if (send_bursty && poll_queue.size() > CALM_TAIL
                            && $urandom_range(0, 3) == 0)
                            send_gap = $urandom_range(1, 17);
                    end
                    else if (awaited_events.size() != 0)
                    begin
                        settle_left = SETTLE_CYCLES;
                    end
                    else if (settle_left > 0)
                    begin
                        settle_left--;
                    end
                    else
                    begin
                        void'(poll_queue.pop_front());
                        cfg_index <= head.index;
                        cfg_data  <= head.data;
                        next_cfg = 1'b1;
                        settle_left = SETTLE_CYCLES;
                    end
                end
            end
            in_valid  <= next_in;
            cfg_valid <= next_cfg;
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            recv_cycles++;
            if (recv_cycles % 64 == 0)
                recv_bursty = ($urandom_range(0, 2) != 0);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (recv_bursty && poll_queue.size() > CALM_TAIL && $urandom_range(0, 4) == 0)
                    stall_left = $urandom_range(1, 17);
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin : watch_proc
        logic [FIELD_W-1:0] want;
        in_xfer_done  <= in_valid && in_ready;
        cfg_xfer_done <= cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                store_register(cfg_index, cfg_data);
            if (in_valid && in_ready)
                awaited_events.push_back(next_press_events(held_buttons));
            if (out_valid && out_ready)
            begin
                if (awaited_events.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected transfer, button_events %h", button_events));
                end
                else
                begin
                    want = awaited_events.pop_front();
                    if (button_events !== want)
                        flag_mismatch($sformatf("result %0d: button_events %h, expected %h",
                                                results_seen, button_events, want));
                end
                results_seen++;
            end
        end
    end

endmodule
